// ===== rtl/rsh_pkg.sv =====
// Shared types and codes for the replacement selection heap.
`default_nettype none
package rsh_pkg;
  localparam int KEY_W    = 14;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_BUILD   = 2'd1,
    KIND_REPLACE = 2'd2,
    KIND_RUNCHK  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef logic [KEY_W:0] rank_t;

  // Ordering value: mark above the key, so marked entries sort last.
  function automatic rank_t rank_of(input logic mark, input logic [KEY_W-1:0] key);
    return {mark, key};
  endfunction
endpackage
`default_nettype wire

// ===== rtl/replacement_selection_heap.sv =====
// Top level: replacement selection min-heap with a sequenced sift-down unit.
`default_nettype none
// Replacement selection heap for run generation. Records sit in one on-chip
// memory (one write, one registered read per cycle); a small sequencer walks
// it, picking the smaller child and comparing it with the record sifted down.
// Load and run check finish as soon as they are taken. Replace reads the
// root, emits it and sifts the new record down from the root. Build finishes
// at once on fewer than two entries; otherwise it reads each internal node,
// from the last one back to the root, and sifts it down. The memory read
// port sets the pace: each sift level reads two children, then writes one
// entry. Marks are held relative to an epoch bit, so a new run flips that
// bit instead of sweeping memory; no clearing pass follows reset. A result
// waits in an output register; the next request is taken once the sequencer
// is idle and that register is free or being drained.
module replacement_selection_heap #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // kind[1:0], new_key[15:2], new_payload above, zero pad to bytes
  input  wire logic [((16+PAYLOAD_BITS+7)/8)*8-1:0] s_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // status[1:0], out_valid[2], out_key[16:3], out_payload, run_started, pad
  output logic [((18+PAYLOAD_BITS+7)/8)*8-1:0] m_tdata
);
  import rsh_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY+1);
  localparam int XW    = AW + 2;
  localparam int OUT_W = ((18+PAYLOAD_BITS+7)/8)*8;
  localparam int EW    = 1 + KEY_W + PAYLOAD_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_RROOT, S_RGET, S_BRD, S_BGET, S_SL, S_SR, S_SC
  } state_t;

  state_t state;
  logic [CW-1:0] count, marked;
  logic          ep;
  logic [AW-1:0] idx, bi;
  logic          building, has_r;
  logic          cur_m, left_m;
  logic [KEY_W-1:0] cur_k, left_k;
  logic [PAYLOAD_BITS-1:0] cur_p, left_p;

  logic [STATUS_W-1:0] o_status;
  logic o_valid, o_run;
  logic [KEY_W-1:0] o_key;
  logic [PAYLOAD_BITS-1:0] o_pay;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  logic [KIND_W-1:0] in_kind;
  logic [KEY_W-1:0]  in_key;
  logic [PAYLOAD_BITS-1:0] in_pay;
  logic accept, out_free;

  logic [XW-1:0] lc, rc, cnt_x;
  logic          rd_m;
  logic [KEY_W-1:0] rd_k;
  logic [PAYLOAD_BITS-1:0] rd_p;
  logic          pick_r, stop;
  logic          ch_m;
  logic [KEY_W-1:0] ch_k;
  logic [PAYLOAD_BITS-1:0] ch_p;
  logic [AW-1:0] ch_idx;
  logic [CW-1:0] half;
  logic          sift_end, res_done;

  assign in_kind  = s_tdata[1:0];
  assign in_key   = s_tdata[15:2];
  assign in_pay   = s_tdata[16+PAYLOAD_BITS-1:16];
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = OUT_W'({o_run, o_pay, o_key, o_valid, o_status});

  assign lc    = ({2'b00, idx} << 1) + XW'(1);
  assign rc    = lc + XW'(1);
  assign cnt_x = XW'(count);
  assign half  = count >> 1;

  // result is ready on this edge: a request that needs no sift, or the last sift ends
  assign sift_end = (state == S_SL && lc >= cnt_x) || (state == S_SC && stop);
  assign res_done = (accept && !(in_kind == KIND_BUILD && half != '0) &&
                     !(in_kind == KIND_REPLACE && count != '0)) ||
                    (sift_end && !(building && bi != '0));

  // stored mark is relative to the epoch bit
  assign rd_m = rd_q[EW-1] ^ ep;
  assign rd_k = rd_q[EW-2 -: KEY_W];
  assign rd_p = rd_q[PAYLOAD_BITS-1:0];

  always_comb begin
    pick_r = has_r && (rank_of(left_m, left_k) > rank_of(rd_m, rd_k));
    ch_m   = pick_r ? rd_m : left_m;
    ch_k   = pick_r ? rd_k : left_k;
    ch_p   = pick_r ? rd_p : left_p;
    ch_idx = pick_r ? rc[AW-1:0] : lc[AW-1:0];
    stop   = rank_of(cur_m, cur_k) <= rank_of(ch_m, ch_k);
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = {cur_m ^ ep, cur_k, cur_p};
    raddr = lc[AW-1:0];
    unique case (state)
      S_IDLE: begin
        raddr = bi;
        if (accept && in_kind == KIND_LOAD && count < CW'(CAPACITY)) begin
          we    = 1'b1;
          waddr = count[AW-1:0];
          wdata = {ep, in_key, in_pay};
        end
      end
      S_RROOT: raddr = '0;
      S_BRD:   raddr = bi;
      S_SL:    we = (lc >= cnt_x);
      S_SR:    raddr = rc[AW-1:0];
      S_SC: begin
        we = 1'b1;
        if (!stop) wdata = {ch_m ^ ep, ch_k, ch_p};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      marked   <= '0;
      ep       <= 1'b0;
      m_tvalid <= 1'b0;
      building <= 1'b0;
      has_r    <= 1'b0;
      idx      <= '0;
      bi       <= '0;
    end else begin
      if (res_done) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            o_status <= (in_kind == KIND_LOAD && count >= CW'(CAPACITY)) ? ST_FULL :
                        (in_kind == KIND_REPLACE && count == '0) ? ST_EMPTY : ST_OK;
            o_valid  <= 1'b0;
            o_key    <= '0;
            o_pay    <= '0;
            o_run    <= (in_kind == KIND_RUNCHK) && (marked == count);
            unique case (kind_t'(in_kind))
              KIND_LOAD: begin
                if (count < CW'(CAPACITY)) count <= count + CW'(1);
              end
              KIND_BUILD: begin
                if (half != '0) begin
                  building <= 1'b1;
                  bi       <= AW'(half - CW'(1));
                  state    <= S_BRD;
                end
              end
              KIND_REPLACE: begin
                if (count != '0) begin
                  building <= 1'b0;
                  cur_k    <= in_key;
                  cur_p    <= in_pay;
                  state    <= S_RROOT;
                end
              end
              KIND_RUNCHK: begin
                if (marked == count) begin
                  ep     <= ~ep;
                  marked <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_RROOT: state <= S_RGET;
        S_RGET: begin
          o_valid <= 1'b1;
          o_key   <= rd_k;
          o_pay   <= rd_p;
          cur_m   <= rd_m || (cur_k < rd_k);
          // marked count follows the record leaving and the one entering
          marked  <= marked - CW'(rd_m) + CW'(rd_m || (cur_k < rd_k));
          idx     <= '0;
          state   <= S_SL;
        end
        S_BRD: state <= S_BGET;
        S_BGET: begin
          cur_m <= rd_m;
          cur_k <= rd_k;
          cur_p <= rd_p;
          idx   <= bi;
          state <= S_SL;
        end
        S_SL: begin
          if (lc >= cnt_x) begin
            if (building && bi != '0) begin
              bi    <= bi - AW'(1);
              state <= S_BRD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_SR;
          end
        end
        S_SR: begin
          left_m <= rd_m;
          left_k <= rd_k;
          left_p <= rd_p;
          has_r  <= (rc < cnt_x);
          state  <= S_SC;
        end
        S_SC: begin
          if (stop) begin
            if (building && bi != '0) begin
              bi    <= bi - AW'(1);
              state <= S_BRD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            idx   <= ch_idx;
            state <= S_SL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rsh_checker.sv =====
// Port-level checks for the replacement selection heap, bound to the top level.
`default_nettype none
module rsh_checker #(
  parameter int OUT_W = 56
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);
  import rsh_pkg::*;

  // a stalled result holds its data
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // an emitted record only comes with an ok status
  a_emit_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1:0] == ST_OK)
    else $error("emitted record with error status");

  // status is always one of the defined codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_FULL ||
                 m_tdata[1:0] == ST_EMPTY)
    else $error("undefined status code");

  // no new request is taken while a result would be overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !m_tvalid || m_tready)
    else $error("request taken with result pending");
endmodule

bind replacement_selection_heap rsh_checker #(
  .OUT_W(((18+PAYLOAD_BITS+7)/8)*8)
) u_rsh_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// ===== dv/tb_replacement_selection_heap.sv =====
// Testbench for the replacement selection heap, checked against a behavioral heap model.
`default_nettype none
module tb_replacement_selection_heap;
  timeunit 1ns;
  timeprecision 1ps;
  import rsh_pkg::*;

  localparam int CAP = 64;
  localparam int PB = 32;
  localparam int SW = ((16+PB+7)/8)*8;
  localparam int MW = ((18+PB+7)/8)*8;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    status_t     status;
    logic        ovalid;
    logic [13:0] okey;
    logic [31:0] opay;
    logic        run;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [SW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [MW-1:0] m_tdata;

  replacement_selection_heap #(.CAPACITY(CAP), .PAYLOAD_BITS(PB)) uut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state
  logic [13:0] mkeys[CAP];
  logic [31:0] mpays[CAP];
  logic        mmarks[CAP];
  int          mcount;

  heap_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  int sink_hold = 0;
  int hold_req = 0;
  int hold_seen = 0;

  function automatic logic [14:0] rank_at(int i);
    return {mmarks[i], mkeys[i]};
  endfunction

  function automatic void swap_at(int a, int b);
    logic [13:0] k;
    logic [31:0] p;
    logic m;
    k = mkeys[a]; p = mpays[a]; m = mmarks[a];
    mkeys[a] = mkeys[b]; mpays[a] = mpays[b]; mmarks[a] = mmarks[b];
    mkeys[b] = k; mpays[b] = p; mmarks[b] = m;
  endfunction

  function automatic void sift(int start);
    int i;
    int j;
    i = start;
    while (1) begin
      j = 2*i + 1;
      if (j >= mcount) break;
      if (j + 1 < mcount && rank_at(j) > rank_at(j+1)) j++;
      if (rank_at(i) <= rank_at(j)) break;
      swap_at(i, j);
      i = j;
    end
  endfunction

  function automatic heap_result_t heap_apply(kind_t kind, logic [13:0] key, logic [31:0] pay);
    heap_result_t r;
    bit all;
    r = '0;
    r.status = ST_OK;
    case (kind)
      KIND_LOAD: begin
        if (mcount >= CAP) r.status = ST_FULL;
        else begin
          mkeys[mcount] = key; mpays[mcount] = pay; mmarks[mcount] = 1'b0;
          mcount++;
        end
      end
      KIND_BUILD: begin
        for (int i = mcount/2 - 1; i >= 0; i--) sift(i);
      end
      KIND_REPLACE: begin
        if (mcount == 0) r.status = ST_EMPTY;
        else begin
          r.ovalid = 1'b1; r.okey = mkeys[0]; r.opay = mpays[0];
          if (key < mkeys[0]) mmarks[0] = 1'b1;
          mkeys[0] = key; mpays[0] = pay;
          sift(0);
        end
      end
      default: begin
        all = 1'b1;
        for (int i = 0; i < mcount; i++) if (!mmarks[i]) all = 1'b0;
        if (all) begin
          for (int i = 0; i < mcount; i++) mmarks[i] = 1'b0;
          r.run = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // tvalid stays high between back-to-back requests; it drops only for a gap
  task automatic send_request(kind_t kind, logic [13:0] key, logic [31:0] pay);
    int gap;
    heap_result_t res;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= SW'({pay, key, kind});
    res = heap_apply(kind, key, pay);
    pending_results = {pending_results, res};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  function automatic logic [13:0] rand_key();
    case ($urandom_range(0, 9))
      0: return 14'd0;
      1: return 14'd10000;
      2: return 14'($urandom_range(0, 16383));
      default: return 14'($urandom_range(0, 10000));
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    heap_result_t got;
    heap_result_t exp;
    if (!rst && m_tvalid && m_tready) begin
      got.status = status_t'(m_tdata[1:0]);
      got.ovalid = m_tdata[2];
      got.okey = m_tdata[16:3];
      got.opay = m_tdata[17+PB-1:17];
      got.run = m_tdata[17+PB];
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", m_tdata);
        errors++;
      end else begin
        exp = pending_results.pop_front();
        if (got.status !== exp.status) begin
          $error("status exp %0d got %0d", exp.status, got.status); errors++;
        end
        if (got.ovalid !== exp.ovalid) begin
          $error("out_valid exp %0d got %0d", exp.ovalid, got.ovalid); errors++;
        end
        if (got.okey !== exp.okey) begin
          $error("out_key exp %0d got %0d", exp.okey, got.okey); errors++;
        end
        if (got.opay !== exp.opay) begin
          $error("out_payload exp %h got %h", exp.opay, got.opay); errors++;
        end
        if (got.run !== exp.run) begin
          $error("run_started exp %0d got %0d", exp.run, got.run); errors++;
        end
      end
    end
  end

  // receiver with random stalls and one long hold-off on request
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_req != hold_seen) begin
      m_tready <= 1'b0;
      sink_hold <= 300;
      hold_seen <= hold_req;
    end else if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (sink_idle_en && m_tready && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      sink_hold <= $urandom_range(0, 17);
    end else m_tready <= 1'b1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_directed;
    send_request(KIND_REPLACE, 14'd5, 32'h1);          // empty replace
    send_request(KIND_RUNCHK, 14'd0, 32'h0);           // empty run check
    send_request(KIND_BUILD, 14'd0, 32'h0);
    send_request(KIND_LOAD, 14'd10000, 32'hFFFF_FFFF);
    send_request(KIND_LOAD, 14'd0, 32'h0);
    send_request(KIND_LOAD, 14'd10000, 32'hA5A5_5A5A);
    send_request(KIND_LOAD, 14'd0, 32'h5A5A_A5A5);
    send_request(KIND_LOAD, 14'd3000, 32'h1234_5678);
    send_request(KIND_BUILD, 14'd0, 32'h0);
    send_request(KIND_RUNCHK, 14'd0, 32'h0);           // unmarked present
    send_request(KIND_REPLACE, 14'd0, 32'hDEAD_BEEF);  // tie with root, not below
    send_request(KIND_REPLACE, 14'd1, 32'hCAFE_F00D);  // above outgoing key: not marked
    send_request(KIND_REPLACE, 14'd10000, 32'h0);
    send_request(KIND_REPLACE, 14'd10000, 32'h1);
    send_request(KIND_REPLACE, 14'd0, 32'h2);
    send_request(KIND_REPLACE, 14'd0, 32'h3);
    send_request(KIND_REPLACE, 14'd0, 32'h4);
    send_request(KIND_RUNCHK, 14'd0, 32'h0);
    drain();
  endtask

  task automatic test_fill_and_stall;
    // fill to capacity with receiver held off, then overflow
    hold_req++;
    for (int i = mcount; i < CAP + 2; i++)
      send_request(KIND_LOAD, rand_key(), $urandom());
    send_request(KIND_BUILD, 14'd0, 32'h0);
    drain();
  endtask

  task automatic test_random(int n, bit idle);
    int r;
    src_idle_en = idle;
    sink_idle_en = idle;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) send_request(KIND_LOAD, rand_key(), $urandom());
      else if (r < 15) send_request(KIND_BUILD, rand_key(), $urandom());
      else if (r < 85) send_request(KIND_REPLACE, rand_key(), $urandom());
      else send_request(KIND_RUNCHK, rand_key(), $urandom());
      if (mcount == 0 && $urandom_range(0, 1) == 0) begin
        // refill a small heap and build it
        repeat ($urandom_range(1, 12)) send_request(KIND_LOAD, rand_key(), $urandom());
        send_request(KIND_BUILD, 14'd0, 32'h0);
      end
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    mcount = 0;
    @(posedge clk);
    test_directed();
    test_fill_and_stall();
    test_random(800, 1'b1);
    test_random(400, 1'b0);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
